### src/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### src/lpmd_pkg.sv
// Types and constants of the length-prefixed message deframer.
package lpmd_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KindByte     = 2'd0;
   localparam kind_type KindDone     = 2'd1;
   localparam kind_type KindByteDone = 2'd2;

   typedef struct packed {
      kind_type    event_kind;
      logic [7:0]  command_code;
      logic [15:0] message_ident;
      logic [15:0] message_length;
      logic [7:0]  byte_index;
      logic [7:0]  byte_value;
      logic        truncated;
   } rsp_payload_type;

endpackage

### src/lpmd_req_if.sv
// Input byte channel of the deframer.
interface lpmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;

   modport source (output valid, output message_byte, input ready);
   modport sink (input valid, input message_byte, output ready);
endinterface

### src/lpmd_rsp_if.sv
// Result event channel of the deframer.
interface lpmd_rsp_if;
   logic               valid;
   logic               ready;
   lpmd_pkg::kind_type event_kind;
   logic [7:0]         command_code;
   logic [15:0]        message_ident;
   logic [15:0]        message_length;
   logic [7:0]         byte_index;
   logic [7:0]         byte_value;
   logic               truncated;

   modport source (output valid, output event_kind, output command_code,
                   output message_ident, output message_length, output byte_index,
                   output byte_value, output truncated, input ready);
   modport sink (input valid, input event_kind, input command_code,
                 input message_ident, input message_length, input byte_index,
                 input byte_value, input truncated, output ready);
endinterface

### src/length_prefixed_message_deframer_top.sv
// Deframer for command/id/length/payload messages, one byte per transaction.
//
// req_chan carries one received byte per transaction; rsp_chan carries one
// event per stored payload byte (with its index) and one at message end with
// the header fields, merged with a stored last byte. Header bytes produce no event
// unless a response command or a zero length ends the message after its length field.
// csr_write_enable/csr_write_data set the response command code.
// A byte is parsed in the cycle it is accepted; its event is registered in
// the result register, or in the skid register while an earlier event waits.
// One byte is taken every cycle while rsp_chan drains; the phase machine and
// one registered event stage set this rate. A two-entry output stage (result
// register plus skid register) lets one more byte in while an event waits;
// req_chan.ready drops only when both entries are full; no event is lost or repeated.
// Payload bytes at or past PAYLOAD_CAPACITY are dropped; the final event
// then carries the clamped length and the truncated flag.
// Synchronous reset returns the parser to the command phase, clears the
// response command and empties the output stage.
`include "assert_macros.svh"
module length_prefixed_message_deframer_top #(
   parameter int PAYLOAD_CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   lpmd_req_if.sink           req_chan,
   lpmd_rsp_if.source         rsp_chan
);

   localparam logic [16:0] CapWide = 17'(PAYLOAD_CAPACITY);
   localparam logic [15:0] CapLen  = 16'(PAYLOAD_CAPACITY);

   localparam logic [1:0] PhaseCommand = 2'd0;
   localparam logic [1:0] PhaseIdent   = 2'd1;
   localparam logic [1:0] PhaseLength  = 2'd2;
   localparam logic [1:0] PhasePayload = 2'd3;

   logic [7:0]  resp_cmd_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] counter_ff, counter_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] length_ff, length_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   lpmd_pkg::rsp_payload_type out_ff, out_in;
   lpmd_pkg::rsp_payload_type skid_ff, skid_in;

   logic                      fire;
   logic                      take;
   logic                      res_valid;
   lpmd_pkg::rsp_payload_type res;
   logic [7:0]                b;
   logic [16:0]               count;
   logic [15:0]               new_ident;
   logic [15:0]               new_length;
   logic                      stored;
   logic                      last;
   logic                      trunc;

   assign b          = req_chan.message_byte;
   assign fire       = req_chan.valid && req_chan.ready;
   assign take       = out_valid_ff && rsp_chan.ready;
   assign count      = {1'b0, counter_ff} + 17'd1;
   assign new_ident  = {ident_ff[7:0], b};
   assign new_length = {length_ff[7:0], b};
   assign stored     = {1'b0, counter_ff} < CapWide;
   assign last       = count >= {1'b0, length_ff};
   assign trunc      = count > CapWide;

   always_comb begin
      phase_in   = phase_ff;
      counter_in = counter_ff;
      command_in = command_ff;
      ident_in   = ident_ff;
      length_in  = length_ff;
      res_valid  = 1'b0;
      res.event_kind     = lpmd_pkg::KindDone;
      res.command_code   = command_ff;
      res.message_ident  = ident_ff;
      res.message_length = length_ff;
      res.byte_index     = 8'd0;
      res.byte_value     = 8'd0;
      res.truncated      = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PhaseCommand: begin
               command_in = b;
               counter_in = 16'd0;
               phase_in   = PhaseIdent;
            end
            PhaseIdent: begin
               ident_in   = new_ident;
               counter_in = count[15:0];
               if (count >= 17'd2) begin
                  counter_in = 16'd0;
                  phase_in   = PhaseLength;
               end
            end
            PhaseLength: begin
               length_in  = new_length;
               counter_in = count[15:0];
               if (count >= 17'd2) begin
                  counter_in = 16'd0;
                  if (command_ff != resp_cmd_ff && new_length != 16'd0) begin
                     phase_in = PhasePayload;
                  end else begin
                     phase_in           = PhaseCommand;
                     res_valid          = 1'b1;
                     res.message_length = new_length;
                  end
               end
            end
            PhasePayload: begin
               counter_in = count[15:0];
               if (!last) begin
                  res_valid      = stored;
                  res.event_kind = lpmd_pkg::KindByte;
                  res.byte_index = counter_ff[7:0];
                  res.byte_value = b;
               end else begin
                  phase_in           = PhaseCommand;
                  res_valid          = 1'b1;
                  res.truncated      = trunc;
                  res.message_length = trunc ? CapLen : length_ff;
                  length_in          = trunc ? CapLen : length_ff;
                  if (stored) begin
                     res.event_kind = lpmd_pkg::KindByteDone;
                     res.byte_index = counter_ff[7:0];
                     res.byte_value = b;
                  end
               end
            end
            default: begin
               phase_in = PhaseCommand;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_cmd_ff   <= 8'd0;
         phase_ff      <= PhaseCommand;
         counter_ff    <= 16'd0;
         command_ff    <= 8'd0;
         ident_ff      <= 16'd0;
         length_ff     <= 16'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            resp_cmd_ff <= csr_write_data;
         end
         phase_ff      <= phase_in;
         counter_ff    <= counter_in;
         command_ff    <= command_in;
         ident_ff      <= ident_in;
         length_ff     <= length_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_chan.ready          = !skid_valid_ff;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.event_kind     = out_ff.event_kind;
   assign rsp_chan.command_code   = out_ff.command_code;
   assign rsp_chan.message_ident  = out_ff.message_ident;
   assign rsp_chan.message_length = out_ff.message_length;
   assign rsp_chan.byte_index     = out_ff.byte_index;
   assign rsp_chan.byte_value     = out_ff.byte_value;
   assign rsp_chan.truncated      = out_ff.truncated;

   `ASSERT_NEVER(a_skid_needs_out, clock, reset, skid_valid_ff && !out_valid_ff)
   `ASSERT_PROP(a_command_to_ident, clock, reset, fire && phase_ff == PhaseCommand |=> phase_ff == PhaseIdent)
   `ASSERT_PROP(a_trunc_len, clock, reset, out_valid_ff && out_ff.truncated |-> out_ff.message_length == CapLen)
   `ASSERT_PROP(a_byte_no_trunc, clock, reset, out_valid_ff && out_ff.event_kind == lpmd_pkg::KindByte |-> !out_ff.truncated)

endmodule
